@@ hw/rtl/lr_pkg.sv @@
// lr_pkg: shared types and constants of the line rasterizer.
// Used by lr_ctrl, lr_datapath and line_rasterizer; no dependencies.
package lr_pkg;

    localparam int COORD_W = 8;
    localparam int PIX_W   = 6;
    localparam int INK_W   = 8;
    localparam int CFG_W   = 7;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

    typedef struct packed {
        logic load;   // latch the command beat
        logic setup;  // range check and orientation
        logic step;   // advance one pixel along the major axis
    } lr_cmd_t;

    typedef struct packed {
        logic last;   // current result is the final one of the command
    } lr_status_t;

endpackage

@@ hw/rtl/line_rasterizer.sv @@
// line_rasterizer: top level, joins lr_ctrl and lr_datapath.
// Depends on lr_pkg, lr_ctrl, lr_datapath.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    start_x start_y end_x end_y ink
//   m_        out        m_valid/m_ready    pixel_x pixel_y pixel_ink bad_params last_pixel
//   cfg_      in         cfg_we             cfg_index cfg_data
//
// A command runs in order: the beat is taken, then range check and
// orientation, then N beats, one per pixel, N = |major delta| + 1 (N = 1 on error).
// The pixel stepper advances only when m_ready takes the current beat.
// s_ready is high only while no command is in flight.
// Reset is synchronous on aresetn; map registers return to 64.
module line_rasterizer #(
    parameter int MAP_DIM = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [lr_pkg::IDX_W-1:0]            cfg_index,
    input  logic [lr_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [lr_pkg::COORD_W-1:0]   s_start_x,
    input  logic signed [lr_pkg::COORD_W-1:0]   s_start_y,
    input  logic signed [lr_pkg::COORD_W-1:0]   s_end_x,
    input  logic signed [lr_pkg::COORD_W-1:0]   s_end_y,
    input  logic [lr_pkg::INK_W-1:0]            s_ink,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lr_pkg::PIX_W-1:0]            m_pixel_x,
    output logic [lr_pkg::PIX_W-1:0]            m_pixel_y,
    output logic [lr_pkg::INK_W-1:0]            m_pixel_ink,
    output logic                                m_bad_params,
    output logic                                m_last_pixel
);

    lr_pkg::lr_cmd_t    cmd;
    lr_pkg::lr_status_t status;

    lr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lr_datapath #(
        .MAP_DIM (MAP_DIM)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .s_ink        (s_ink),
        .cmd          (cmd),
        .status       (status),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_pixel_ink  (m_pixel_ink),
        .m_bad_params (m_bad_params),
        .m_last_pixel (m_last_pixel)
    );

endmodule

@@ hw/rtl/lr_ctrl.sv @@
// lr_ctrl: command sequencer of the line rasterizer.
// Depends on lr_pkg; drives lr_datapath through lr_cmd_t.
module lr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  lr_pkg::lr_status_t status,
    output lr_pkg::lr_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_EMIT);

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.setup  = 1'b0;
        cmd.step   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (m_ready) begin
                    if (status.last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_to_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && !m_valid))
        else $error("command beat not followed by setup");

    a_pixels_continue: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !status.last) |=> m_valid)
        else $error("line ended before last pixel");

    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && status.last) |=> (s_ready && !m_valid))
        else $error("not idle after last pixel");

    a_step_only_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (m_valid && m_ready && !status.last))
        else $error("step without a taken beat");

endmodule

@@ hw/rtl/lr_datapath.sv @@
// lr_datapath: map registers, command latch, range check and error-term stepper.
// Depends on lr_pkg; controlled by lr_ctrl.
module lr_datapath #(
    parameter int MAP_DIM = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [lr_pkg::IDX_W-1:0]            cfg_index,
    input  logic [lr_pkg::CFG_W-1:0]            cfg_data,
    input  logic signed [lr_pkg::COORD_W-1:0]   s_start_x,
    input  logic signed [lr_pkg::COORD_W-1:0]   s_start_y,
    input  logic signed [lr_pkg::COORD_W-1:0]   s_end_x,
    input  logic signed [lr_pkg::COORD_W-1:0]   s_end_y,
    input  logic [lr_pkg::INK_W-1:0]            s_ink,
    input  lr_pkg::lr_cmd_t                     cmd,
    output lr_pkg::lr_status_t                  status,
    output logic [lr_pkg::PIX_W-1:0]            m_pixel_x,
    output logic [lr_pkg::PIX_W-1:0]            m_pixel_y,
    output logic [lr_pkg::INK_W-1:0]            m_pixel_ink,
    output logic                                m_bad_params,
    output logic                                m_last_pixel
);

    localparam logic [lr_pkg::CFG_W-1:0] DIM_LIM = lr_pkg::CFG_W'(MAP_DIM);

    logic [lr_pkg::CFG_W-1:0] map_width_reg;
    logic [lr_pkg::CFG_W-1:0] map_height_reg;

    logic signed [7:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [7:0]        ink_reg;

    logic [5:0]        maj_reg, maj_next;
    logic [5:0]        min_reg, min_next;
    logic [5:0]        steps_left_reg, steps_left_next;
    logic signed [7:0] dmin2_reg, dmin2_next;
    logic [6:0]        dmaj2_reg, dmaj2_next;
    logic signed [8:0] err_reg, err_next;
    logic              x_major_reg, x_major_next;
    logic              bad_reg, bad_next;

    logic [6:0]        w_eff, h_eff;
    logic              in_range;
    logic signed [8:0] dx, dy, dmaj, dmin;
    logic [8:0]        adx, ady;
    logic              x_major;
    logic [5:0]        maj_a, min_a;
    logic signed [8:0] e_sum, dmaj2_s;

    assign w_eff = (map_width_reg  > DIM_LIM) ? DIM_LIM : map_width_reg;
    assign h_eff = (map_height_reg > DIM_LIM) ? DIM_LIM : map_height_reg;

    assign in_range = !x0_reg[7] && (x0_reg[6:0] < w_eff)
                   && !x1_reg[7] && (x1_reg[6:0] < w_eff)
                   && !y0_reg[7] && (y0_reg[6:0] < h_eff)
                   && !y1_reg[7] && (y1_reg[6:0] < h_eff);

    assign dx  = $signed({x1_reg[7], x1_reg}) - $signed({x0_reg[7], x0_reg});
    assign dy  = $signed({y1_reg[7], y1_reg}) - $signed({y0_reg[7], y0_reg});
    assign adx = dx[8] ? 9'(-dx) : 9'(dx);
    assign ady = dy[8] ? 9'(-dy) : 9'(dy);
    assign x_major = (adx >= ady) && (dx != 9'sd0);

    always_comb begin
        if (x_major) begin
            if (!dx[8]) begin
                maj_a = x0_reg[5:0]; min_a = y0_reg[5:0]; dmaj = dx;  dmin = dy;
            end else begin
                maj_a = x1_reg[5:0]; min_a = y1_reg[5:0]; dmaj = -dx; dmin = -dy;
            end
        end else begin
            if (!dy[8]) begin
                maj_a = y0_reg[5:0]; min_a = x0_reg[5:0]; dmaj = dy;  dmin = dx;
            end else begin
                maj_a = y1_reg[5:0]; min_a = x1_reg[5:0]; dmaj = -dy; dmin = -dx;
            end
        end
    end

    assign dmaj2_s = $signed({2'b00, dmaj2_reg});
    assign e_sum   = err_reg + $signed({dmin2_reg[7], dmin2_reg});

    always_comb begin
        maj_next        = maj_reg;
        min_next        = min_reg;
        steps_left_next = steps_left_reg;
        dmin2_next      = dmin2_reg;
        dmaj2_next      = dmaj2_reg;
        err_next        = err_reg;
        x_major_next    = x_major_reg;
        bad_next        = bad_reg;
        if (cmd.setup) begin
            bad_next        = !in_range;
            x_major_next    = x_major;
            maj_next        = maj_a;
            min_next        = min_a;
            steps_left_next = dmaj[5:0];
            dmaj2_next      = {dmaj[5:0], 1'b0};
            dmin2_next      = {dmin[6:0], 1'b0};
            err_next        = $signed({3'b000, dmaj[5:0]});
        end else if (cmd.step) begin
            maj_next        = maj_reg + 6'd1;
            steps_left_next = steps_left_reg - 6'd1;
            priority if (e_sum >= dmaj2_s) begin
                min_next = min_reg + 6'd1;
                err_next = e_sum - dmaj2_s;
            end else if (e_sum < 9'sd0) begin
                min_next = min_reg - 6'd1;
                err_next = e_sum + dmaj2_s;
            end else begin
                err_next = e_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= 7'd64;
            map_height_reg <= 7'd64;
        end else if (cfg_we) begin
            if (cfg_index == lr_pkg::REG_MAP_WIDTH) begin
                map_width_reg <= cfg_data;
            end else if (cfg_index == lr_pkg::REG_MAP_HEIGHT) begin
                map_height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x0_reg  <= s_start_x;
            y0_reg  <= s_start_y;
            x1_reg  <= s_end_x;
            y1_reg  <= s_end_y;
            ink_reg <= s_ink;
        end
        maj_reg        <= maj_next;
        min_reg        <= min_next;
        steps_left_reg <= steps_left_next;
        dmin2_reg      <= dmin2_next;
        dmaj2_reg      <= dmaj2_next;
        err_reg        <= err_next;
        x_major_reg    <= x_major_next;
        bad_reg        <= bad_next;
    end

    assign status.last  = bad_reg || (steps_left_reg == 6'd0);
    assign m_last_pixel = status.last;
    assign m_bad_params = bad_reg;
    assign m_pixel_x    = bad_reg ? 6'd0 : (x_major_reg ? maj_reg : min_reg);
    assign m_pixel_y    = bad_reg ? 6'd0 : (x_major_reg ? min_reg : maj_reg);
    assign m_pixel_ink  = bad_reg ? 8'd0 : ink_reg;

endmodule
